/* rtl/lrp_pkg.sv */
package lrp_pkg;

  // fixed field widths of the channels
  localparam int unsigned PAGE_NUM_W  = 16;
  localparam int unsigned FRAME_IDX_W = 3;
  localparam int unsigned COUNT_W     = 32;
  localparam int unsigned STAMP_W     = 32;

  // configuration port
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned FIU_W      = 4;
  localparam logic [FIU_W-1:0] FIU_RESET = 4'd8;

  // register index, taken from paddr[2]
  typedef enum logic [0:0] {
    REG_FRAMES_IN_USE = 1'b0,
    REG_UNUSED        = 1'b1
  } reg_idx_t;

  // one result transaction
  typedef struct packed {
    logic                   hit;
    logic [FRAME_IDX_W-1:0] frame_index;
    logic                   evicted_valid;
    logic [PAGE_NUM_W-1:0]  evicted_page;
    logic [COUNT_W-1:0]     fault_count;
    logic [COUNT_W-1:0]     hit_count;
  } lrp_result_t;

endpackage

/* rtl/lrp_if.sv */
// page reference channel
interface lrp_in_if import lrp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [PAGE_NUM_W-1:0] page_number;

  modport source (output valid, output page_number, input ready);
  modport sink (input valid, input page_number, output ready);
endinterface

// replacement result channel
interface lrp_out_if import lrp_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   hit;
  logic [FRAME_IDX_W-1:0] frame_index;
  logic                   evicted_valid;
  logic [PAGE_NUM_W-1:0]  evicted_page;
  logic [COUNT_W-1:0]     fault_count;
  logic [COUNT_W-1:0]     hit_count;

  modport source (output valid, output hit, output frame_index, output evicted_valid,
                  output evicted_page, output fault_count, output hit_count, input ready);
  modport sink (input valid, input hit, input frame_index, input evicted_valid,
                input evicted_page, input fault_count, input hit_count, output ready);
endinterface

/* rtl/lru_page_replacement.sv */
// channel   direction  handshake         payload
// in_ch     in         valid/ready       page_number
// out_ch    out        valid/ready       hit, frame_index, evicted_valid/page, counts
// cfg_*     in/out     apb, pready high  frames_in_use at byte address 0
//
// a reference is taken in idle, then the scan reads all n active frames (n being the active frame count):
// the frame memory has a single read port, so the scan reads one frame a cycle.
// a new reference is taken while the previous result waits in the output register.
// rst_n is synchronous: it empties all frames and clears the counters, no clearing pass.
// a stalled result holds the block in its write-back step until taken.
module lru_page_replacement import lrp_pkg::*; #(
  parameter int unsigned FRAMES    = 8,
  parameter int unsigned PAGE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  lrp_in_if.sink                in_ch,
  lrp_out_if.source             out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int unsigned IDX_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned ENTRY_W = PAGE_BITS + STAMP_W;

  logic [FIU_W-1:0]   frames_in_use;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  // configuration register
  lrp_cfg u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_prdata    (cfg_prdata),
    .cfg_pready    (cfg_pready),
    .frames_in_use (frames_in_use)
  );

  // scan and update sequencer
  lrp_ctrl #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS),
    .IDX_W     (IDX_W),
    .ENTRY_W   (ENTRY_W)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .frames_in_use (frames_in_use),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata)
  );

  // page and stamp of each frame
  lrp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (FRAMES)
  ) u_frame_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // one reference at a time: no second transaction right after one is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input taken while a reference is in progress");

  // a hit never evicts
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.hit && out_ch.evicted_valid))
    else $error("hit reported together with an eviction");

  // evicted page reads zero when nothing was replaced
  a_evict_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.evicted_valid |-> out_ch.evicted_page == '0)
    else $error("evicted page nonzero without an eviction");

endmodule

/* rtl/lrp_ram.sv */
module lrp_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/lrp_cfg.sv */
module lrp_cfg import lrp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,
  output logic [FIU_W-1:0]      frames_in_use
);

  logic [FIU_W-1:0] fiu_r;
  reg_idx_t         reg_idx;
  logic             wr_en;

  assign reg_idx    = reg_idx_t'(cfg_paddr[2]);
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // register write in the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fiu_r <= FIU_RESET;
    end else if (wr_en && reg_idx == REG_FRAMES_IN_USE) begin
      fiu_r <= cfg_pwdata[FIU_W-1:0];
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      REG_FRAMES_IN_USE: cfg_prdata = CFG_DATA_W'(fiu_r);
      default:           cfg_prdata = '0;
    endcase
  end

  assign frames_in_use = fiu_r;

endmodule

/* rtl/lrp_ctrl.sv */
module lrp_ctrl import lrp_pkg::*; #(
  parameter int unsigned FRAMES    = 8,
  parameter int unsigned PAGE_BITS = 16,
  parameter int unsigned IDX_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1,
  parameter int unsigned ENTRY_W   = PAGE_BITS + STAMP_W
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [FIU_W-1:0]   frames_in_use,
  lrp_in_if.sink             in_ch,
  lrp_out_if.source          out_ch,
  output logic               ram_we,
  output logic [IDX_W-1:0]   ram_waddr,
  output logic [ENTRY_W-1:0] ram_wdata,
  output logic [IDX_W-1:0]   ram_raddr,
  input  logic [ENTRY_W-1:0] ram_rdata
);

  localparam int unsigned CNT_W = $clog2(FRAMES + 1);
  localparam int unsigned PX_W  = PAGE_BITS + PAGE_NUM_W;
  localparam int unsigned FX_W  = IDX_W + FRAME_IDX_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE
  } state_t;

  state_t                 state_r;
  logic [FRAMES-1:0]      valid_r;
  logic [STAMP_W-1:0]     use_cnt_r;
  logic [COUNT_W-1:0]     faults_r;
  logic [COUNT_W-1:0]     hits_r;
  logic                   out_valid_r;
  lrp_result_t            res_r;

  logic [PAGE_BITS-1:0]   page_r;
  logic [CNT_W-1:0]       n_r;
  logic [CNT_W-1:0]       issue_r;
  logic                   pend_r;
  logic [IDX_W-1:0]       pend_idx_r;
  logic                   found_r;
  logic [IDX_W-1:0]       hit_pos_r;
  logic                   have_empty_r;
  logic [IDX_W-1:0]       empty_pos_r;
  logic                   have_old_r;
  logic [STAMP_W-1:0]     old_stamp_r;
  logic [IDX_W-1:0]       old_pos_r;
  logic [PAGE_BITS-1:0]   old_page_r;

  logic [PX_W-1:0]        in_page_x;
  logic [CNT_W-1:0]       n_active;
  logic [PAGE_BITS-1:0]   rd_page;
  logic [STAMP_W-1:0]     rd_stamp;
  logic                   rd_valid;
  logic                   rd_match;
  logic                   rd_older;
  logic                   out_free;
  logic                   evict;
  logic [IDX_W-1:0]       pos;
  logic [FX_W-1:0]        pos_x;
  logic [PX_W-1:0]        ev_page_x;
  logic [STAMP_W-1:0]     stamp_new;
  logic [COUNT_W-1:0]     faults_new;
  logic [COUNT_W-1:0]     hits_new;

  // page taken at its stored width
  assign in_page_x = PX_W'(in_ch.page_number);

  // frame count clamped to 1..FRAMES
  always_comb begin
    if (frames_in_use == '0) begin
      n_active = CNT_W'(1);
    end else if (32'(frames_in_use) > 32'(FRAMES)) begin
      n_active = CNT_W'(FRAMES);
    end else begin
      n_active = CNT_W'(frames_in_use);
    end
  end

  // compare of the entry read in the previous cycle
  assign rd_page  = ram_rdata[PAGE_BITS-1:0];
  assign rd_stamp = ram_rdata[PAGE_BITS +: STAMP_W];
  assign rd_valid = valid_r[pend_idx_r];
  assign rd_match = (rd_page == page_r);
  assign rd_older = !have_old_r || (rd_stamp < old_stamp_r);

  // frame choice and new counts
  assign evict      = !found_r && !have_empty_r;
  assign pos        = found_r ? hit_pos_r : (have_empty_r ? empty_pos_r : old_pos_r);
  assign pos_x      = FX_W'(pos);
  assign ev_page_x  = PX_W'(old_page_r);
  assign stamp_new  = use_cnt_r + STAMP_W'(1);
  assign faults_new = faults_r + COUNT_W'(!found_r);
  assign hits_new   = hits_r + COUNT_W'(found_r);
  assign out_free   = !out_valid_r || out_ch.ready;

  // memory ports
  assign ram_raddr = issue_r[IDX_W-1:0];
  assign ram_we    = (state_r == S_WRITE) && out_free;
  assign ram_waddr = pos;
  assign ram_wdata = {stamp_new, page_r};

  // sequencer, frame state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      use_cnt_r   <= '0;
      faults_r    <= '0;
      hits_r      <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && !ram_we) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            page_r       <= in_page_x[PAGE_BITS-1:0];
            n_r          <= n_active;
            issue_r      <= '0;
            pend_r       <= 1'b0;
            found_r      <= 1'b0;
            have_empty_r <= 1'b0;
            have_old_r   <= 1'b0;
            state_r      <= S_SCAN;
          end
        end
        S_SCAN: begin
          // issue one read a cycle
          pend_r     <= (issue_r < n_r);
          pend_idx_r <= issue_r[IDX_W-1:0];
          if (issue_r < n_r) begin
            issue_r <= issue_r + CNT_W'(1);
          end else begin
            state_r <= S_WRITE;
          end
          // fold the returned entry into hit, empty and oldest
          if (pend_r) begin
            if (rd_valid) begin
              if (!found_r && rd_match) begin
                found_r   <= 1'b1;
                hit_pos_r <= pend_idx_r;
              end
              if (rd_older) begin
                have_old_r  <= 1'b1;
                old_stamp_r <= rd_stamp;
                old_pos_r   <= pend_idx_r;
                old_page_r  <= rd_page;
              end
            end else if (!have_empty_r) begin
              have_empty_r <= 1'b1;
              empty_pos_r  <= pend_idx_r;
            end
          end
        end
        S_WRITE: begin
          if (out_free) begin
            valid_r[pos]        <= 1'b1;
            use_cnt_r           <= stamp_new;
            faults_r            <= faults_new;
            hits_r              <= hits_new;
            res_r.hit           <= found_r;
            res_r.frame_index   <= pos_x[FRAME_IDX_W-1:0];
            res_r.evicted_valid <= evict;
            res_r.evicted_page  <= evict ? ev_page_x[PAGE_NUM_W-1:0] : '0;
            res_r.fault_count   <= faults_new;
            res_r.hit_count     <= hits_new;
            out_valid_r         <= 1'b1;
            state_r             <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // channel outputs
  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.hit           = res_r.hit;
  assign out_ch.frame_index   = res_r.frame_index;
  assign out_ch.evicted_valid = res_r.evicted_valid;
  assign out_ch.evicted_page  = res_r.evicted_page;
  assign out_ch.fault_count   = res_r.fault_count;
  assign out_ch.hit_count     = res_r.hit_count;

endmodule
